@@ hw/rtl/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types, constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  localparam int unsigned CacheEntriesDef    = 16;
  localparam int unsigned InflightEntriesDef = 8;

  localparam logic [1:0] CmdResolve = 2'd0;
  localparam logic [1:0] CmdPacket  = 2'd1;
  localparam logic [1:0] CmdTick    = 2'd2;

  localparam logic [1:0] RegLocalIp  = 2'd0;
  localparam logic [1:0] RegLocalMac = 2'd1;
  localparam logic [1:0] RegTtl      = 2'd2;
  localparam logic [1:0] RegGap      = 2'd3;

  localparam logic [31:0] BcastIp     = 32'hFFFF_FFFF;
  localparam logic [47:0] BcastMac    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] TtlReset    = 48'd300000;
  localparam logic [15:0] GapReset    = 16'd250;
  localparam logic [15:0] HwEthernet  = 16'd1;
  localparam logic [15:0] ProtoIpv4   = 16'h0800;
  localparam logic [15:0] OpRequest   = 16'd1;
  localparam logic [10:0] MinArpLen   = 11'd28;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch input beat, run lookups
    logic execute;  // update tables, build result
  } arp_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/arp_resolution_cache.sv @@
// ----------------------------------------------------------------------------
// ARP resolution cache
// Resolves IPv4 to MAC, learns from ARP packets, ages entries on ticks.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_stall_o with one field port each; a beat is
// taken when valid is high and stall low. cmd 0 resolves peer_ip, cmd 1
// is a received ARP packet, cmd 2 a time tick.
// Output channel: out_valid_o/out_stall_i; exactly one result beat per
// input beat, fields that do not apply are zero.
// Configuration: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// Sequencing: one beat in flight. Capture and table compare happen in the
// idle state, the update in the look state, then the result is held in the
// output state.
// A stalled result holds its value, and input stays stalled until the
// result beat is taken.
// Reset clears both tables, current time and configuration to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_resolution_cache #(
  parameter int unsigned CacheEntries    = arp_pkg::CacheEntriesDef,
  parameter int unsigned InflightEntries = arp_pkg::InflightEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] peer_ip_i,
  input  wire logic [47:0] peer_mac_i,
  input  wire logic [31:0] asked_ip_i,
  input  wire logic [15:0] arp_op_i,
  input  wire logic [15:0] hw_kind_i,
  input  wire logic [15:0] proto_kind_i,
  input  wire logic [10:0] packet_length_i,
  input  wire logic [47:0] now_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             resolved_o,
  output logic [47:0]      out_mac_o,
  output logic             send_request_o,
  output logic [31:0]      request_ip_o,
  output logic             send_reply_o,
  output logic [31:0]      reply_ip_o,
  output logic [47:0]      reply_mac_o
);
  import arp_pkg::*;

  arp_cmd_t cmd;

  arp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd)
  );

  arp_dp #(.CacheEntries(CacheEntries), .InflightEntries(InflightEntries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_in_i(cmd_i), .peer_ip_i, .peer_mac_i, .asked_ip_i, .arp_op_i,
    .hw_kind_i, .proto_kind_i, .packet_length_i, .now_ms_i,
    .resolved_o, .out_mac_o, .send_request_o, .request_ip_o,
    .send_reply_o, .reply_ip_o, .reply_mac_o
  );

endmodule

`default_nettype wire

@@ hw/rtl/arp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences capture, execute and result hand-off for one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output arp_pkg::arp_cmd_t  cmd_o
);
  import arp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StLook;
        end
      end
      StLook: begin
        cmd_o.execute = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/arp_dp.sv @@
// ----------------------------------------------------------------------------
// ARP cache datapath
// Cache and in-flight tables, lookups, replacement and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_dp #(
  parameter int unsigned CacheEntries    = arp_pkg::CacheEntriesDef,
  parameter int unsigned InflightEntries = arp_pkg::InflightEntriesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire arp_pkg::arp_cmd_t cmd_i,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [47:0]   cfg_data_i,
  input  wire logic [1:0]    cmd_in_i,
  input  wire logic [31:0]   peer_ip_i,
  input  wire logic [47:0]   peer_mac_i,
  input  wire logic [31:0]   asked_ip_i,
  input  wire logic [15:0]   arp_op_i,
  input  wire logic [15:0]   hw_kind_i,
  input  wire logic [15:0]   proto_kind_i,
  input  wire logic [10:0]   packet_length_i,
  input  wire logic [47:0]   now_ms_i,
  output logic               resolved_o,
  output logic [47:0]        out_mac_o,
  output logic               send_request_o,
  output logic [31:0]        request_ip_o,
  output logic               send_reply_o,
  output logic [31:0]        reply_ip_o,
  output logic [47:0]        reply_mac_o
);
  import arp_pkg::*;

  localparam int unsigned CW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned PW = (InflightEntries > 1) ? $clog2(InflightEntries) : 1;
  localparam int unsigned CP = 1 << CW;

  logic [31:0] local_ip_q;
  logic [47:0] local_mac_q, ttl_q;
  logic [15:0] gap_q;
  logic [47:0] cur_time_q;

  logic [CacheEntries-1:0] c_vld_q;
  logic [31:0] c_ip_q   [CacheEntries];
  logic [47:0] c_mac_q  [CacheEntries];
  logic [47:0] c_time_q [CacheEntries];
  logic [InflightEntries-1:0] p_vld_q;
  logic [31:0] p_ip_q   [InflightEntries];
  logic [47:0] p_sent_q [InflightEntries];

  // captured beat
  logic [1:0]  cmd_q;
  logic [31:0] ip_q, asked_q;
  logic [47:0] mac_q, now_q;
  logic        pkt_ok_q, req_q;

  // lookup results registered at capture
  logic          c_hit_q, c_free_q, p_hit_q, p_free_q;
  logic [CW-1:0] c_hit_idx_q, c_free_idx_q, c_old_idx_q;
  logic [PW-1:0] p_hit_idx_q, p_free_idx_q;
  logic [InflightEntries-1:0] p_match_q;

  // match/search over the tables (small register tables, parallel compare)
  logic          c_hit, c_free, p_hit, p_free;
  logic [CW-1:0] c_hit_idx, c_free_idx, c_old_idx;
  logic [PW-1:0] p_hit_idx, p_free_idx;
  logic [InflightEntries-1:0] p_match;

  // oldest-entry search as a compare tree
  logic [CW-1:0] old_idx_n  [2*CP-1];
  logic [47:0]   old_time_n [2*CP-1];

  always_comb begin
    c_hit = 1'b0; c_free = 1'b0; c_hit_idx = '0; c_free_idx = '0;
    for (int i = 0; i < CacheEntries; i++) begin
      if (!c_hit && c_vld_q[i] && c_ip_q[i] == peer_ip_i) begin
        c_hit = 1'b1; c_hit_idx = CW'(i);
      end
      if (!c_free && !c_vld_q[i]) begin
        c_free = 1'b1; c_free_idx = CW'(i);
      end
    end
    p_hit = 1'b0; p_free = 1'b0; p_hit_idx = '0; p_free_idx = '0;
    for (int j = 0; j < InflightEntries; j++) begin
      p_match[j] = p_vld_q[j] && p_ip_q[j] == peer_ip_i;
      if (!p_hit && p_match[j]) begin
        p_hit = 1'b1; p_hit_idx = PW'(j);
      end
      if (!p_free && !p_vld_q[j]) begin
        p_free = 1'b1; p_free_idx = PW'(j);
      end
    end
  end

  // pad leaves copy entry 0; the left side wins ties, so lowest index is kept
  always_comb begin
    for (int k = 0; k < CP; k++) begin
      if (k < CacheEntries) begin
        old_idx_n[CP-1+k]  = CW'(k);
        old_time_n[CP-1+k] = c_time_q[k];
      end else begin
        old_idx_n[CP-1+k]  = '0;
        old_time_n[CP-1+k] = c_time_q[0];
      end
    end
    for (int n = int'(CP) - 2; n >= 0; n--) begin
      if (old_time_n[2*n+2] < old_time_n[2*n+1]) begin
        old_idx_n[n]  = old_idx_n[2*n+2];
        old_time_n[n] = old_time_n[2*n+2];
      end else begin
        old_idx_n[n]  = old_idx_n[2*n+1];
        old_time_n[n] = old_time_n[2*n+1];
      end
    end
    c_old_idx = old_idx_n[0];
  end

  // throttle check on the registered hit entry
  logic [47:0] sent_sel;
  logic        gap_ok;
  assign sent_sel = p_sent_q[p_hit_idx_q];
  assign gap_ok = (cur_time_q == '0) || (sent_sel == '0) || (cur_time_q < sent_sel) ||
                  ((cur_time_q - sent_sel) >= {32'd0, gap_q});

  logic [CW-1:0] learn_idx;
  assign learn_idx = c_hit_q ? c_hit_idx_q : (c_free_q ? c_free_idx_q : c_old_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= cmd_in_i;
      ip_q     <= peer_ip_i;
      asked_q  <= asked_ip_i;
      mac_q    <= peer_mac_i;
      now_q    <= now_ms_i;
      pkt_ok_q <= (packet_length_i >= MinArpLen) && (hw_kind_i == HwEthernet) &&
                  (proto_kind_i == ProtoIpv4);
      req_q    <= (arp_op_i == OpRequest);
      c_hit_q <= c_hit; c_free_q <= c_free; p_hit_q <= p_hit; p_free_q <= p_free;
      c_hit_idx_q <= c_hit_idx; c_free_idx_q <= c_free_idx; c_old_idx_q <= c_old_idx;
      p_hit_idx_q <= p_hit_idx; p_free_idx_q <= p_free_idx;
      p_match_q <= p_match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q <= '0; local_mac_q <= '0; ttl_q <= TtlReset; gap_q <= GapReset;
      cur_time_q <= '0;
      c_vld_q <= '0; p_vld_q <= '0;
      for (int i = 0; i < CacheEntries; i++) begin
        c_ip_q[i] <= '0; c_mac_q[i] <= '0; c_time_q[i] <= '0;
      end
      for (int j = 0; j < InflightEntries; j++) begin
        p_ip_q[j] <= '0; p_sent_q[j] <= '0;
      end
      resolved_o <= 1'b0; out_mac_o <= '0; send_request_o <= 1'b0;
      request_ip_o <= '0; send_reply_o <= 1'b0; reply_ip_o <= '0; reply_mac_o <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLocalIp:  local_ip_q  <= cfg_data_i[31:0];
          RegLocalMac: local_mac_q <= cfg_data_i;
          RegTtl:      ttl_q       <= cfg_data_i;
          RegGap:      gap_q       <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.execute) begin
        resolved_o <= 1'b0; out_mac_o <= '0; send_request_o <= 1'b0;
        request_ip_o <= '0; send_reply_o <= 1'b0; reply_ip_o <= '0; reply_mac_o <= '0;
        case (cmd_q)
          CmdResolve: begin
            if (ip_q == BcastIp) begin
              resolved_o <= 1'b1; out_mac_o <= BcastMac;
            end else if (c_hit_q) begin
              resolved_o <= 1'b1; out_mac_o <= c_mac_q[c_hit_idx_q];
            end else if (ip_q != '0) begin
              if (p_hit_q) begin
                if (gap_ok) begin
                  p_sent_q[p_hit_idx_q] <= cur_time_q;
                  send_request_o <= 1'b1; request_ip_o <= ip_q;
                end
              end else begin
                p_vld_q[p_free_q ? p_free_idx_q : '0]  <= 1'b1;
                p_ip_q[p_free_q ? p_free_idx_q : '0]   <= ip_q;
                p_sent_q[p_free_q ? p_free_idx_q : '0] <= cur_time_q;
                send_request_o <= 1'b1; request_ip_o <= ip_q;
              end
            end
          end
          CmdPacket: begin
            if (pkt_ok_q) begin
              c_vld_q[learn_idx]  <= 1'b1;
              c_ip_q[learn_idx]   <= ip_q;
              c_mac_q[learn_idx]  <= mac_q;
              c_time_q[learn_idx] <= cur_time_q;
              for (int j = 0; j < InflightEntries; j++) begin
                if (p_match_q[j]) begin
                  p_vld_q[j] <= 1'b0; p_ip_q[j] <= '0; p_sent_q[j] <= '0;
                end
              end
              if (req_q && asked_q == local_ip_q) begin
                send_reply_o <= 1'b1; reply_ip_o <= ip_q; reply_mac_o <= mac_q;
              end
            end
          end
          CmdTick: begin
            cur_time_q <= now_q;
            if (now_q != '0) begin
              for (int i = 0; i < CacheEntries; i++) begin
                if (c_vld_q[i] && c_time_q[i] != '0 &&
                    ((now_q < c_time_q[i]) || ((now_q - c_time_q[i]) > ttl_q)))
                  c_vld_q[i] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // own MAC is stored here but drives no output of this block
  logic unused_mac;
  assign unused_mac = ^local_mac_q;

endmodule

`default_nettype wire

@@ bench/arp_resolution_cache_test.sv @@
// ----------------------------------------------------------------------------
// ARP resolution cache testbench
// Drives resolves, ARP packets and ticks with random gaps and output stalls,
// predicts every result beat from a local copy of the cache and in-flight
// tables, and checks each result field against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
  logic [1:0]  cmd;
  logic [31:0] peer_ip;
  logic [47:0] peer_mac;
  logic [31:0] asked_ip;
  logic [15:0] arp_op;
  logic [15:0] hw_kind;
  logic [15:0] proto_kind;
  logic [10:0] packet_length;
  logic [47:0] now_ms;
} arp_beat_t;

typedef struct {
  logic        resolved;
  logic [47:0] out_mac;
  logic        send_request;
  logic [31:0] request_ip;
  logic        send_reply;
  logic [31:0] reply_ip;
  logic [47:0] reply_mac;
} arp_result_t;

class arp_scoreboard;
  localparam int NCache = arp_pkg::CacheEntriesDef;
  localparam int NPend  = arp_pkg::InflightEntriesDef;

  logic [31:0] local_ip;
  logic [47:0] local_mac;
  logic [47:0] ttl_ms;
  logic [15:0] gap_ms;
  logic        c_valid[NCache];
  logic [31:0] c_ip[NCache];
  logic [47:0] c_mac[NCache];
  logic [47:0] c_time[NCache];
  logic        p_valid[NPend];
  logic [31:0] p_ip[NPend];
  logic [47:0] p_sent[NPend];
  logic [47:0] now_time;
  arp_result_t pending_results[$];
  int          errors;

  function new();
    local_ip = '0;
    local_mac = '0;
    ttl_ms = arp_pkg::TtlReset;
    gap_ms = arp_pkg::GapReset;
    now_time = '0;
    errors = 0;
    for (int i = 0; i < NCache; i++) begin
      c_valid[i] = 1'b0; c_ip[i] = '0; c_mac[i] = '0; c_time[i] = '0;
    end
    for (int i = 0; i < NPend; i++) begin
      p_valid[i] = 1'b0; p_ip[i] = '0; p_sent[i] = '0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [47:0] data);
    case (idx)
      arp_pkg::RegLocalIp:  local_ip = data[31:0];
      arp_pkg::RegLocalMac: local_mac = data;
      arp_pkg::RegTtl:      ttl_ms = data;
      default:              gap_ms = data[15:0];
    endcase
  endfunction

  // backwards time counts as unbounded
  function logic [63:0] span(logic [47:0] later, logic [47:0] earlier);
    if (later < earlier) return '1;
    return 64'(later - earlier);
  endfunction

  function void drop_inflight(logic [31:0] ip);
    for (int i = 0; i < NPend; i++)
      if (p_valid[i] && p_ip[i] == ip) begin
        p_valid[i] = 1'b0; p_ip[i] = '0; p_sent[i] = '0;
      end
  endfunction

  function logic track_request(logic [31:0] ip);
    int slot;
    slot = 0;
    if (ip == 0) return 1'b0;
    for (int i = 0; i < NPend; i++)
      if (p_valid[i] && p_ip[i] == ip) begin
        if (now_time == 0 || p_sent[i] == 0 || span(now_time, p_sent[i]) >= 64'(gap_ms)) begin
          p_sent[i] = now_time;
          return 1'b1;
        end
        return 1'b0;
      end
    for (int i = NPend - 1; i >= 0; i--)
      if (!p_valid[i]) slot = i;
    p_valid[slot] = 1'b1;
    p_ip[slot] = ip;
    p_sent[slot] = now_time;
    return 1'b1;
  endfunction

  function void learn_pair(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = -1;
    for (int i = 0; i < NCache; i++)
      if (c_valid[i] && c_ip[i] == ip) begin
        c_mac[i] = mac;
        c_time[i] = now_time;
        drop_inflight(ip);
        return;
      end
    for (int i = NCache - 1; i >= 0; i--)
      if (!c_valid[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < NCache; i++)
        if (c_time[i] < c_time[slot]) slot = i;
    end
    c_valid[slot] = 1'b1;
    c_ip[slot] = ip;
    c_mac[slot] = mac;
    c_time[slot] = now_time;
    drop_inflight(ip);
  endfunction

  function void note_input(arp_beat_t b);
    arp_result_t r;
    logic hit;
    r = '{default: '0};
    hit = 1'b0;
    case (b.cmd)
      arp_pkg::CmdResolve: begin
        if (b.peer_ip == arp_pkg::BcastIp) begin
          r.resolved = 1'b1;
          r.out_mac = arp_pkg::BcastMac;
        end else begin
          for (int i = 0; i < NCache; i++)
            if (!hit && c_valid[i] && c_ip[i] == b.peer_ip) begin
              hit = 1'b1;
              r.resolved = 1'b1;
              r.out_mac = c_mac[i];
            end
          if (!hit && track_request(b.peer_ip)) begin
            r.send_request = 1'b1;
            r.request_ip = b.peer_ip;
          end
        end
      end
      arp_pkg::CmdPacket: begin
        if (b.packet_length >= arp_pkg::MinArpLen && b.hw_kind == arp_pkg::HwEthernet &&
            b.proto_kind == arp_pkg::ProtoIpv4) begin
          learn_pair(b.peer_ip, b.peer_mac);
          if (b.arp_op == arp_pkg::OpRequest && b.asked_ip == local_ip) begin
            r.send_reply = 1'b1;
            r.reply_ip = b.peer_ip;
            r.reply_mac = b.peer_mac;
          end
        end
      end
      arp_pkg::CmdTick: begin
        now_time = b.now_ms;
        if (b.now_ms != 0)
          for (int i = 0; i < NCache; i++)
            if (c_valid[i] && c_time[i] != 0 && span(b.now_ms, c_time[i]) > 64'(ttl_ms))
              c_valid[i] = 1'b0;
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endfunction

  function void check_result(arp_result_t a);
    arp_result_t e;
    if (pending_results.size() == 0) begin
      $error("result beat with no expectation");
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (a.resolved !== e.resolved) begin
      $error("resolved: expected %0h actual %0h", e.resolved, a.resolved); errors++;
    end
    if (a.out_mac !== e.out_mac) begin
      $error("out_mac: expected %0h actual %0h", e.out_mac, a.out_mac); errors++;
    end
    if (a.send_request !== e.send_request) begin
      $error("send_request: expected %0h actual %0h", e.send_request, a.send_request);
      errors++;
    end
    if (a.request_ip !== e.request_ip) begin
      $error("request_ip: expected %0h actual %0h", e.request_ip, a.request_ip); errors++;
    end
    if (a.send_reply !== e.send_reply) begin
      $error("send_reply: expected %0h actual %0h", e.send_reply, a.send_reply); errors++;
    end
    if (a.reply_ip !== e.reply_ip) begin
      $error("reply_ip: expected %0h actual %0h", e.reply_ip, a.reply_ip); errors++;
    end
    if (a.reply_mac !== e.reply_mac) begin
      $error("reply_mac: expected %0h actual %0h", e.reply_mac, a.reply_mac); errors++;
    end
  endfunction
endclass

module arp_resolution_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int RandomBeats   = 1400;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [47:0] cfg_data;
  logic        in_valid, in_stall;
  logic [1:0]  cmd;
  logic [31:0] peer_ip, asked_ip;
  logic [47:0] peer_mac, now_ms;
  logic [15:0] arp_op, hw_kind, proto_kind;
  logic [10:0] packet_length;
  logic        out_valid, out_stall;
  logic        resolved, send_request, send_reply;
  logic [47:0] out_mac, reply_mac;
  logic [31:0] request_ip, reply_ip;

  arp_scoreboard sb;
  logic   hold_off;     // long receiver hold-off request
  logic   stim_done;
  int     idle_cycles;
  logic [31:0] ip_pool[8];
  logic [47:0] clock_ms;

  arp_resolution_cache i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .peer_ip_i(peer_ip), .peer_mac_i(peer_mac), .asked_ip_i(asked_ip),
    .arp_op_i(arp_op), .hw_kind_i(hw_kind), .proto_kind_i(proto_kind),
    .packet_length_i(packet_length), .now_ms_i(now_ms),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .resolved_o(resolved), .out_mac_o(out_mac),
    .send_request_o(send_request), .request_ip_o(request_ip),
    .send_reply_o(send_reply), .reply_ip_o(reply_ip), .reply_mac_o(reply_mac)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_cfg(logic [1:0] idx, logic [47:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every expected result has arrived, plus a little margin
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic send_beat(arp_beat_t b);
    in_valid <= 1'b1;
    cmd <= b.cmd; peer_ip <= b.peer_ip; peer_mac <= b.peer_mac;
    asked_ip <= b.asked_ip; arp_op <= b.arp_op; hw_kind <= b.hw_kind;
    proto_kind <= b.proto_kind; packet_length <= b.packet_length; now_ms <= b.now_ms;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    @(negedge clk);
  endtask

  task automatic send_with_gap(arp_beat_t b);
    int g;
    send_beat(b);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic arp_beat_t good_packet(logic [31:0] ip, logic [47:0] mac,
                                            logic [31:0] asked, logic [15:0] op);
    arp_beat_t b;
    b = '{cmd: arp_pkg::CmdPacket, peer_ip: ip, peer_mac: mac, asked_ip: asked,
          arp_op: op, hw_kind: arp_pkg::HwEthernet, proto_kind: arp_pkg::ProtoIpv4,
          packet_length: 11'($urandom_range(28, 2047)), now_ms: '0};
    return b;
  endfunction

  function automatic arp_beat_t resolve_of(logic [31:0] ip);
    arp_beat_t b;
    b = '{default: '0};
    b.cmd = arp_pkg::CmdResolve;
    b.peer_ip = ip;
    b.peer_mac = {$urandom, $urandom};
    b.now_ms = {$urandom, $urandom};
    return b;
  endfunction

  function automatic arp_beat_t tick_at(logic [47:0] t);
    arp_beat_t b;
    b = '{default: '0};
    b.cmd = arp_pkg::CmdTick;
    b.now_ms = t;
    return b;
  endfunction

  function automatic arp_beat_t noise_beat();
    arp_beat_t b;
    b.cmd = 2'($urandom);
    b.peer_ip = $urandom;
    b.peer_mac = {$urandom, $urandom};
    b.asked_ip = $urandom;
    b.arp_op = 16'($urandom);
    b.hw_kind = ($urandom_range(0, 1) != 0) ? arp_pkg::HwEthernet : 16'($urandom);
    b.proto_kind = ($urandom_range(0, 1) != 0) ? arp_pkg::ProtoIpv4 : 16'($urandom);
    b.packet_length = 11'($urandom);
    b.now_ms = {$urandom, $urandom};
    return b;
  endfunction

  function automatic arp_beat_t random_beat();
    arp_beat_t b;
    logic [31:0] ip;
    int k;
    k = $urandom_range(0, 99);
    ip = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, 7)];
    if (k < 40) begin
      b = resolve_of(ip);
    end else if (k < 70) begin
      b = good_packet(ip, {$urandom, $urandom},
                      ($urandom_range(0, 1) != 0) ? sb.local_ip : $urandom,
                      16'($urandom_range(1, 2)));
    end else if (k < 88) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 400));
      if ($urandom_range(0, 19) == 0) clock_ms = {$urandom, $urandom};
      b = tick_at(($urandom_range(0, 29) == 0) ? 48'd0 : clock_ms);
    end else begin
      b = noise_beat();
    end
    return b;
  endfunction

  // output side: random stalls plus a forced long hold-off
  initial begin
    int g;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        out_stall <= (g > 0);
        if (g > 0) repeat (g) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.check_result('{resolved, out_mac, send_request, request_ip,
                        send_reply, reply_ip, reply_mac});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    arp_beat_t b;
    sb = new();
    hold_off = 1'b0;
    stim_done = 1'b0;
    idle_cycles = 0;
    clock_ms = 48'd1000;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_valid = 1'b0;
    cmd = '0; peer_ip = '0; peer_mac = '0; asked_ip = '0; arp_op = '0;
    hw_kind = '0; proto_kind = '0; packet_length = '0; now_ms = '0;
    for (int i = 0; i < 8; i++) ip_pool[i] = 32'h0A00_0001 + 32'(i);
    ip_pool[7] = 32'hFFFF_FFFE;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset defaults first
    send_with_gap(resolve_of(arp_pkg::BcastIp));
    send_with_gap(resolve_of(32'd0));                // zero address miss
    send_with_gap(resolve_of(ip_pool[0]));           // miss, request
    send_with_gap(resolve_of(ip_pool[0]));           // time unknown, request again
    send_with_gap(tick_at(48'd0));                   // unknown time
    send_with_gap(tick_at(48'd1000));
    send_with_gap(resolve_of(ip_pool[0]));           // throttle refresh
    send_with_gap(resolve_of(ip_pool[0]));           // throttled
    b = good_packet(ip_pool[0], 48'hFFFF_FFFF_FFFF, 32'd0, arp_pkg::OpRequest);
    send_with_gap(b);                                // learn + reply
    b.packet_length = 11'd27; send_with_gap(b);      // short packet
    b = good_packet(ip_pool[1], '0, '1, 16'hFFFF); b.hw_kind = 16'hFFFF; send_with_gap(b);
    b = good_packet(ip_pool[1], '0, '1, 16'd2); b.proto_kind = '0; send_with_gap(b);
    send_with_gap(resolve_of(ip_pool[0]));           // hit
    b = noise_beat(); b.cmd = 2'd3; send_with_gap(b); // unused command
    send_with_gap(tick_at(48'd500));                 // time going backwards
    send_with_gap(tick_at(48'hFFFF_FFFF_FFFF));
    for (int i = 0; i < 9; i++)                      // overfill in-flight table
      send_with_gap(resolve_of(32'h0B00_0000 + 32'(i)));
    drain();

    // register extremes, then fill the cache past capacity
    write_cfg(arp_pkg::RegLocalIp, 48'hFFFF_FFFF);
    write_cfg(arp_pkg::RegLocalMac, 48'hFFFF_FFFF_FFFF);
    write_cfg(arp_pkg::RegTtl, 48'd1);
    write_cfg(arp_pkg::RegGap, 48'd0);
    send_with_gap(tick_at(48'd10));
    for (int i = 0; i < 18; i++) begin
      send_with_gap(good_packet(32'h0C00_0000 + 32'(i), {$urandom, $urandom},
                                32'hFFFF_FFFF, arp_pkg::OpRequest));
      if (i % 4 == 3) send_with_gap(tick_at(48'd10 + 48'(i)));
    end
    send_with_gap(tick_at(48'd40));                  // ages every cached entry
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_cfg(arp_pkg::RegLocalIp, {16'd0, ip_pool[$urandom_range(0, 7)]});
      write_cfg(arp_pkg::RegLocalMac, {$urandom, $urandom});
      write_cfg(arp_pkg::RegTtl, (phase == 3) ? 48'hFFFF_FFFF_FFFF :
                                  48'($urandom_range(1, 3000)));
      write_cfg(arp_pkg::RegGap, (phase == 2) ? 48'hFFFF : 48'($urandom_range(0, 600)));
      for (int n = 0; n < RandomBeats / 4; n++) begin
        if (phase == 1 && n == 50) hold_off = 1'b1;
        if (phase == 1 && n == 90) hold_off = 1'b0;
        if (n == 200) drain();                       // sender pause until all results
        send_with_gap(random_beat());
      end
      in_valid <= 1'b0;
      drain();
    end

    stim_done = 1'b1;
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

`default_nettype wire
